@@ rtl/core/reno_pkg.sv @@
// Shared types and constants for the Reno congestion window block.
package reno_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned SegW  = 16;
  localparam int unsigned InitW = 5;
  localparam int unsigned DupW  = 8;

  localparam logic [WordW-1:0] AllOnes     = '1;
  localparam logic [DupW-1:0]  DupMax      = 8'd255;
  localparam logic [DupW-1:0]  DupFastRtx  = 8'd3;
  localparam logic [SegW-1:0]  SegReset    = 16'd1400;
  localparam logic [InitW-1:0] InitReset   = 5'd10;

  // Event kinds on the input channel
  typedef enum logic [1:0] {
    CMD_NEW_ACK = 2'd0,
    CMD_DUP_ACK = 2'd1,
    CMD_TIMEOUT = 2'd2,
    CMD_OPEN    = 2'd3
  } cmd_t;

  // Register index on the configuration port
  localparam logic REG_SEGMENT_SIZE     = 1'b0;
  localparam logic REG_INITIAL_SEGMENTS = 1'b1;

  // Divider request and response
  typedef struct packed {
    logic             start;
    logic [WordW-1:0] dividend;
    logic [WordW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [WordW-1:0] quotient;
  } div_rsp_t;

endpackage

@@ rtl/core/reno_div.sv @@
// Radix-2 restoring divider, one quotient bit per cycle.
module reno_div
  import reno_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int unsigned CntW = $clog2(WordW);

  typedef enum logic {
    D_IDLE,
    D_RUN
  } dstate_t;

  dstate_t          state_r;
  logic [CntW-1:0]  cnt_r;
  logic [WordW-1:0] rem_r;
  logic [WordW-1:0] quo_r;
  logic [WordW-1:0] dvs_r;
  logic             done_r;

  logic [WordW:0]   shifted;
  logic [WordW:0]   diff;
  logic             ge;

  // One restoring step: shift in next dividend bit, trial subtract
  always_comb begin
    shifted = {rem_r, quo_r[WordW-1]};
    diff    = shifted - {1'b0, dvs_r};
    ge      = !diff[WordW];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        D_IDLE: begin
          if (req.start) begin
            state_r <= D_RUN;
            cnt_r   <= '0;
          end
        end
        D_RUN: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CntW'(WordW - 1)) begin
            state_r <= D_IDLE;
            done_r  <= 1'b1;
          end
        end
        default: state_r <= D_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (state_r == D_IDLE && req.start) begin
      rem_r <= '0;
      quo_r <= req.dividend;
      dvs_r <= req.divisor;
    end else if (state_r == D_RUN) begin
      rem_r <= ge ? diff[WordW-1:0] : shifted[WordW-1:0];
      quo_r <= {quo_r[WordW-2:0], ge};
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

@@ rtl/core/reno_congestion_window.sv @@
// Top level: Reno congestion window sequencer with shared serial divider.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+---------------------------------------
//  in_     | in  | in_tvalid/in_tready  | tuser: cmd; tdata: acked, flight
//  out_    | out | out_tvalid/out_tready| tdata: cwnd, ssthresh, rec, dup, rtx
//  cfg_    | in  | APB psel/penable     | segment_size @0x0, initial_segs @0x4
//
// An accepted event goes to S_CALC, then S_OUT shows the registered result; a
// new ACK in congestion avoidance first waits in S_DIV for the 32-step serial
// divider computing seg^2/cwnd (start, 32 steps, done). One event is in work
// at a time; in_tready is high only while idle.
// The result register holds until out_tready; the next event waits for it.
// Reset (rst_n, synchronous) loads cwnd = 14000, ssthresh = all ones.
module reno_congestion_window
  import reno_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Event input
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] acked_bytes, [63:32] flight_bytes
  input  logic [1:0]  in_tuser,   // [1:0] cmd
  // Result output
  output logic        out_tvalid,
  input  logic        out_tready,
  // [31:0] congestion_window, [63:32] slow_start_threshold, [64] in_recovery,
  // [72:65] dup_ack_count, [73] fast_retransmit, [79:74] zero
  output logic [79:0] out_tdata,
  // Configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CALC,
    S_DIV,
    S_OUT
  } state_t;

  state_t           state_r;
  logic [SegW-1:0]  seg_r;
  logic [InitW-1:0] init_r;
  logic [WordW-1:0] win_r, win_nxt;
  logic [WordW-1:0] thr_r, thr_nxt;
  logic             rec_r, rec_nxt;
  logic [DupW-1:0]  dup_r, dup_nxt;
  logic             rtx_r, rtx_nxt;
  cmd_t             cmd_r;
  logic [WordW-1:0] acked_r;
  logic [WordW-1:0] flight_r;
  logic             need_div;

  div_req_t         div_req;
  div_rsp_t         div_rsp;

  logic [WordW-1:0] half_thr;
  logic [SegW:0]    seg_x2;
  logic [SegW+1:0]  seg_x3;
  logic [WordW-1:0] ss_inc;
  logic [WordW-1:0] dup_inc;
  logic [WordW-1:0] ca_inc;
  logic [WordW:0]   win_sum;
  logic [WordW:0]   thr_sum;
  logic [WordW:0]   ca_sum;
  logic [2*SegW-1:0] seg_sq;
  logic [SegW+InitW-1:0] open_win;
  logic             cfg_wr;

  // Configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r  <= SegReset;
      init_r <= InitReset;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_SEGMENT_SIZE:     seg_r  <= cfg_pwdata[SegW-1:0];
        REG_INITIAL_SEGMENTS: init_r <= cfg_pwdata[InitW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_SEGMENT_SIZE:     cfg_prdata = {{(32-SegW){1'b0}}, seg_r};
      REG_INITIAL_SEGMENTS: cfg_prdata = {{(32-InitW){1'b0}}, init_r};
      default:              cfg_prdata = '0;
    endcase
  end

  // Event arithmetic: threshold halving, increments, saturating adds
  always_comb begin
    seg_x2   = {seg_r, 1'b0};
    seg_x3   = {1'b0, seg_x2} + {2'b00, seg_r};
    half_thr = (flight_r >> 1) > {{(WordW-SegW-1){1'b0}}, seg_x2}
             ? (flight_r >> 1) : {{(WordW-SegW-1){1'b0}}, seg_x2};
    ss_inc   = acked_r < {{(WordW-SegW){1'b0}}, seg_r}
             ? acked_r : {{(WordW-SegW){1'b0}}, seg_r};
    dup_inc  = {{(WordW-SegW){1'b0}}, seg_r};
    // slow start or recovery inflation share one adder
    win_sum  = {1'b0, win_r} + {1'b0, (cmd_r == CMD_NEW_ACK) ? ss_inc : dup_inc};
    thr_sum  = {1'b0, half_thr} + {{(WordW-SegW-1){1'b0}}, seg_x3};
    ca_inc   = (div_rsp.quotient == '0) ? WordW'(1) : div_rsp.quotient;
    ca_sum   = {1'b0, win_r} + {1'b0, ca_inc};
    seg_sq   = {{SegW{1'b0}}, seg_r} * {{SegW{1'b0}}, seg_r};
    open_win = {{SegW{1'b0}}, init_r} * {{InitW{1'b0}}, seg_r};
  end

  // Next state of the connection for one event
  always_comb begin
    win_nxt  = win_r;
    thr_nxt  = thr_r;
    rec_nxt  = rec_r;
    dup_nxt  = dup_r;
    rtx_nxt  = 1'b0;
    need_div = 1'b0;
    unique case (cmd_r)
      CMD_NEW_ACK: begin
        dup_nxt = '0;
        if (rec_r) begin
          rec_nxt = 1'b0;
          win_nxt = thr_r;
        end else if (win_r < thr_r) begin
          win_nxt = win_sum[WordW] ? AllOnes : win_sum[WordW-1:0];
        end else begin
          need_div = 1'b1;
        end
      end
      CMD_DUP_ACK: begin
        dup_nxt = (dup_r == DupMax) ? DupMax : dup_r + 1'b1;
        if (dup_nxt == DupFastRtx && !rec_r) begin
          thr_nxt = half_thr;
          win_nxt = thr_sum[WordW] ? AllOnes : thr_sum[WordW-1:0];
          rec_nxt = 1'b1;
          rtx_nxt = 1'b1;
        end else if (rec_r) begin
          win_nxt = win_sum[WordW] ? AllOnes : win_sum[WordW-1:0];
        end
      end
      CMD_TIMEOUT: begin
        if (win_r != '0) begin
          thr_nxt = half_thr;
          win_nxt = {{(WordW-SegW){1'b0}}, seg_r};
          dup_nxt = '0;
          rec_nxt = 1'b0;
        end
      end
      CMD_OPEN: begin
        win_nxt = {{(WordW-SegW-InitW){1'b0}}, open_win};
        thr_nxt = AllOnes;
        rec_nxt = 1'b0;
        dup_nxt = '0;
      end
      default: ;
    endcase
  end

  // Divider request: seg^2 / cwnd
  assign div_req.start    = (state_r == S_CALC) && need_div;
  assign div_req.dividend = seg_sq;
  assign div_req.divisor  = win_r;

  reno_div u_div (
    .clk (clk),
    .rst_n (rst_n),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Sequencer and connection state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      win_r   <= WordW'(InitReset * SegReset);
      thr_r   <= AllOnes;
      rec_r   <= 1'b0;
      dup_r   <= '0;
      rtx_r   <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            state_r <= S_CALC;
          end
        end
        S_CALC: begin
          thr_r <= thr_nxt;
          rec_r <= rec_nxt;
          dup_r <= dup_nxt;
          rtx_r <= rtx_nxt;
          if (need_div) begin
            state_r <= S_DIV;
          end else begin
            win_r   <= win_nxt;
            state_r <= S_OUT;
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            win_r   <= ca_sum[WordW] ? AllOnes : ca_sum[WordW-1:0];
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_tready) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Event capture
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      cmd_r    <= cmd_t'(in_tuser);
      acked_r  <= in_tdata[31:0];
      flight_r <= in_tdata[63:32];
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = {6'd0, rtx_r, dup_r, rec_r, thr_r, win_r};

`ifndef SYNTHESIS
  // Input and output sides never both open
  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("in_tready and out_tvalid high together");

  // Fast retransmit reported only on entry to recovery at the third dup ack
  a_rtx_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && rtx_r) |-> (rec_r && dup_r == DupFastRtx))
    else $error("fast retransmit without recovery entry");

  // Divider finishes only while the sequencer waits for it
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_DIV))
    else $error("divider done outside wait state");

  // Accepted event reaches the compute step next cycle
  a_accept_calc: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_CALC))
    else $error("accepted event did not enter compute");
`endif

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the Reno congestion window block.
module testbench;
  import reno_pkg::*;

  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned SettleCycles = 40;  // divider latency plus margin
  localparam int unsigned LongHoldCycles = 400;
  localparam int unsigned PhaseItems = 120;

  typedef struct packed {
    logic [31:0] cwnd;
    logic [31:0] ssthresh;
    logic        rec;
    logic [7:0]  dups;
    logic        rtx;
  } cc_result_t;

  // One row of stimulus: either a register write or an event
  typedef struct packed {
    logic        is_cfg;
    logic        cfg_idx;
    logic [31:0] cfg_value;
    cmd_t        cmd;
    logic [31:0] acked;
    logic [31:0] flight;
    logic        typed;
    cc_result_t  want;
  } stim_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  reno_congestion_window dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor copy of the connection state and registers
  logic [15:0] seg_cfg;
  logic [4:0]  init_cfg;
  logic [31:0] win_q;
  logic [31:0] thresh_q;
  logic        recov_q;
  logic [7:0]  dupcnt_q;

  stim_t       plan_q[$];
  cc_result_t  pending_results[$];
  int unsigned error_count = 0;
  int unsigned results_seen = 0;
  int unsigned cycle_count = 0;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [63:0] b);
    logic [64:0] sum;
    sum = {33'd0, a} + {1'b0, b};
    return (sum > {33'd0, AllOnes}) ? AllOnes : sum[31:0];
  endfunction

  // max(flight/2, two segments)
  function automatic logic [31:0] halved_thresh(input logic [31:0] flight);
    logic [31:0] floor2;
    floor2 = {15'd0, seg_cfg, 1'b0};
    return ((flight >> 1) > floor2) ? (flight >> 1) : floor2;
  endfunction

  // Advance the predicted state by one event and return the result it shows
  function automatic cc_result_t reno_next(input cmd_t cmd, input logic [31:0] acked,
                                           input logic [31:0] flight);
    cc_result_t  r;
    logic [63:0] inc;
    logic        rtx;
    rtx = 1'b0;
    case (cmd)
      CMD_NEW_ACK: begin
        dupcnt_q = '0;
        if (recov_q) begin
          recov_q = 1'b0;
          win_q = thresh_q;
        end else if (win_q < thresh_q) begin
          inc = (acked < {16'd0, seg_cfg}) ? {32'd0, acked} : {48'd0, seg_cfg};
          win_q = sat_add(win_q, inc);
        end else begin
          // congestion avoidance: seg^2 / cwnd, at least one byte
          if (win_q == '0) inc = {32'd0, AllOnes};
          else inc = ({48'd0, seg_cfg} * {48'd0, seg_cfg}) / {32'd0, win_q};
          if (inc == '0) inc = 64'd1;
          win_q = sat_add(win_q, inc);
        end
      end
      CMD_DUP_ACK: begin
        if (dupcnt_q != DupMax) dupcnt_q = dupcnt_q + 8'd1;
        if (dupcnt_q == DupFastRtx && !recov_q) begin
          thresh_q = halved_thresh(flight);
          win_q = sat_add(thresh_q, 64'd3 * {48'd0, seg_cfg});
          recov_q = 1'b1;
          rtx = 1'b1;
        end else if (recov_q) begin
          win_q = sat_add(win_q, {48'd0, seg_cfg});
        end
      end
      CMD_TIMEOUT: begin
        if (win_q != '0) begin
          thresh_q = halved_thresh(flight);
          win_q = {16'd0, seg_cfg};
          dupcnt_q = '0;
          recov_q = 1'b0;
        end
      end
      default: begin
        win_q = {27'd0, init_cfg} * {16'd0, seg_cfg};
        thresh_q = AllOnes;
        recov_q = 1'b0;
        dupcnt_q = '0;
      end
    endcase
    r.cwnd = win_q;
    r.ssthresh = thresh_q;
    r.rec = recov_q;
    r.dups = dupcnt_q;
    r.rtx = rtx;
    return r;
  endfunction

  // Stimulus table rows
  task automatic add_event(input cmd_t cmd, input logic [31:0] acked, input logic [31:0] flight);
    stim_t s;
    s = '0;
    s.cmd = cmd;
    s.acked = acked;
    s.flight = flight;
    plan_q.push_back(s);
  endtask

  task automatic add_typed(input cmd_t cmd, input logic [31:0] acked, input logic [31:0] flight,
                           input logic [31:0] cwnd, input logic [31:0] ssthresh,
                           input logic rec, input logic [7:0] dups, input logic rtx);
    stim_t s;
    s = '0;
    s.cmd = cmd;
    s.acked = acked;
    s.flight = flight;
    s.typed = 1'b1;
    s.want.cwnd = cwnd;
    s.want.ssthresh = ssthresh;
    s.want.rec = rec;
    s.want.dups = dups;
    s.want.rtx = rtx;
    plan_q.push_back(s);
  endtask

  task automatic add_cfg(input logic idx, input logic [31:0] value);
    stim_t s;
    s = '0;
    s.is_cfg = 1'b1;
    s.cfg_idx = idx;
    s.cfg_value = value;
    plan_q.push_back(s);
  endtask

  function automatic logic [31:0] pick_acked(input int unsigned seg);
    case ($urandom_range(0, 5))
      0: return '0;
      1: return AllOnes;
      2: return $urandom_range(0, 2 * seg);
      3, 4: return $urandom_range(1, seg + 1);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_flight(input int unsigned seg);
    case ($urandom_range(0, 5))
      0: return AllOnes;
      1: return $urandom_range(0, 1);
      2, 3: return $urandom_range(0, 12 * seg + 1);
      default: return $urandom;
    endcase
  endfunction

  // Mostly well-formed ack sequences with random content, plus noise
  task automatic fill_random(input int unsigned count, input int unsigned seg,
                             input bit long_dup_run);
    int unsigned start;
    int unsigned k;
    int unsigned pick;
    logic [31:0] flight;
    start = plan_q.size();
    if (long_dup_run) begin
      // drives the duplicate count into saturation
      flight = pick_flight(seg);
      for (k = 0; k < 262; k++) add_event(CMD_DUP_ACK, $urandom, flight);
      add_event(CMD_NEW_ACK, pick_acked(seg), $urandom);
    end
    while (plan_q.size() - start < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        for (k = $urandom_range(1, 8); k > 0; k--)
          add_event(CMD_NEW_ACK, pick_acked(seg), $urandom);
      end else if (pick < 55) begin
        flight = pick_flight(seg);
        for (k = $urandom_range(1, 6); k > 0; k--) add_event(CMD_DUP_ACK, $urandom, flight);
        if ($urandom_range(0, 2) != 0) add_event(CMD_NEW_ACK, pick_acked(seg), $urandom);
      end else if (pick < 68) begin
        add_event(CMD_TIMEOUT, $urandom, pick_flight(seg));
      end else if (pick < 73) begin
        add_event(CMD_OPEN, $urandom, $urandom);
      end else if (pick < 88) begin
        add_event(cmd_t'($urandom_range(0, 3)), $urandom, $urandom);
      end else begin
        flight = pick_flight(seg);
        for (k = $urandom_range(3, 10); k > 0; k--) add_event(CMD_DUP_ACK, $urandom, flight);
        add_event(CMD_NEW_ACK, pick_acked(seg), $urandom);
      end
    end
  endtask

  // Present one event, wait for its handshake, then record the expected result
  task automatic send_event(input stim_t s, input int unsigned gap);
    cc_result_t predicted;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= s.cmd;
    in_tdata <= {s.flight, s.acked};
    do @(posedge clk); while (!(in_tvalid && in_tready));
    predicted = reno_next(s.cmd, s.acked, s.flight);
    pending_results.push_back(s.typed ? s.want : predicted);
  endtask

  // APB write: setup cycle, then access cycle until pready
  task automatic write_reg(input logic idx, input logic [31:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (idx == REG_SEGMENT_SIZE) seg_cfg = value[15:0];
    else init_cfg = value[4:0];
  endtask

  // Wait for every outstanding result, then let the block settle
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic run_plan();
    stim_t       s;
    int unsigned n;
    bit          quiet;
    n = 0;
    quiet = 1'b0;
    while (plan_q.size() != 0) begin
      s = plan_q.pop_front();
      if (s.is_cfg) begin
        drain();
        write_reg(s.cfg_idx, s.cfg_value);
      end else begin
        if (n % 64 == 0) quiet = ($urandom_range(0, 3) == 0);
        send_event(s, quiet ? 0 : $urandom_range(0, 15));
        n++;
      end
    end
  endtask

  // Receiver: random stalls, bursts without stalls, and one long hold-off
  initial begin : receiver
    int unsigned stall;
    int unsigned n;
    bit          quiet;
    bit          long_hold_done;
    n = 0;
    quiet = 1'b0;
    long_hold_done = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (n % 50 == 0) quiet = ($urandom_range(0, 3) == 0);
      stall = quiet ? 0 : $urandom_range(0, 15);
      if (!long_hold_done && results_seen >= 200) begin
        stall = LongHoldCycles;
        long_hold_done = 1'b1;
      end
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
      n++;
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    cc_result_t want;
    cc_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen <= results_seen + 1;
      got.cwnd = out_tdata[31:0];
      got.ssthresh = out_tdata[63:32];
      got.rec = out_tdata[64];
      got.dups = out_tdata[72:65];
      got.rtx = out_tdata[73];
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_tdata);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.cwnd !== want.cwnd) begin
          $display("%0t: cwnd expected %h actual %h", $time, want.cwnd, got.cwnd);
          error_count++;
        end
        if (got.ssthresh !== want.ssthresh) begin
          $display("%0t: ssthresh expected %h actual %h", $time, want.ssthresh, got.ssthresh);
          error_count++;
        end
        if (got.rec !== want.rec) begin
          $display("%0t: in_recovery expected %b actual %b", $time, want.rec, got.rec);
          error_count++;
        end
        if (got.dups !== want.dups) begin
          $display("%0t: dup_ack_count expected %0d actual %0d", $time, want.dups, got.dups);
          error_count++;
        end
        if (got.rtx !== want.rtx) begin
          $display("%0t: fast_retransmit expected %b actual %b", $time, want.rtx, got.rtx);
          error_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin : main
    int unsigned segs [8];
    int unsigned inits [8];
    int unsigned p;
    segs = '{1, 65535, 536, 0, 1460, 9000, 65535, 1};
    inits = '{1, 16, 4, 31, 0, 2, 31, 16};
    seg_cfg = SegReset;
    init_cfg = InitReset;
    win_q = {27'd0, InitReset} * {16'd0, SegReset};
    thresh_q = AllOnes;
    recov_q = 1'b0;
    dupcnt_q = '0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset registers (1400-byte segments, 10 initial segments)
    add_typed(CMD_OPEN, '0, '0, 32'd14000, AllOnes, 1'b0, 8'd0, 1'b0);
    add_event(CMD_NEW_ACK, '0, AllOnes);
    add_event(CMD_NEW_ACK, AllOnes, '0);
    add_event(CMD_NEW_ACK, 32'd700, $urandom);
    add_event(CMD_DUP_ACK, AllOnes, '0);
    add_event(CMD_DUP_ACK, '0, AllOnes);
    add_typed(CMD_DUP_ACK, '0, 32'd100000, 32'd54200, 32'd50000, 1'b1, 8'd3, 1'b1);
    add_event(CMD_DUP_ACK, '0, '0);
    // full ack ends recovery and deflates to the threshold
    add_typed(CMD_NEW_ACK, '0, '0, 32'd50000, 32'd50000, 1'b0, 8'd0, 1'b0);
    add_event(CMD_NEW_ACK, 32'd1, '0);
    add_typed(CMD_TIMEOUT, '0, '0, 32'd1400, 32'd2800, 1'b0, 8'd0, 1'b0);
    add_typed(CMD_TIMEOUT, '0, AllOnes, 32'd1400, 32'h7fffffff, 1'b0, 8'd0, 1'b0);
    add_event(CMD_DUP_ACK, '0, 32'd1);
    add_event(CMD_DUP_ACK, '0, 32'd1);
    add_typed(CMD_DUP_ACK, '0, 32'd1, 32'd7000, 32'd2800, 1'b1, 8'd3, 1'b1);
    // open while in recovery
    add_typed(CMD_OPEN, AllOnes, AllOnes, 32'd14000, AllOnes, 1'b0, 8'd0, 1'b0);
    // zero segment size: zero window, timeout on zero window, saturation
    add_cfg(REG_SEGMENT_SIZE, 32'd0);
    add_typed(CMD_TIMEOUT, '0, 32'd1, '0, '0, 1'b0, 8'd0, 1'b0);
    add_typed(CMD_DUP_ACK, '0, '0, '0, '0, 1'b0, 8'd1, 1'b0);
    add_typed(CMD_TIMEOUT, '0, 32'd7, '0, '0, 1'b0, 8'd1, 1'b0);
    add_typed(CMD_NEW_ACK, 32'd9, '0, AllOnes, '0, 1'b0, 8'd0, 1'b0);
    add_typed(CMD_NEW_ACK, AllOnes, '0, AllOnes, '0, 1'b0, 8'd0, 1'b0);
    add_typed(CMD_OPEN, '0, '0, '0, AllOnes, 1'b0, 8'd0, 1'b0);
    add_typed(CMD_NEW_ACK, 32'd100, '0, '0, AllOnes, 1'b0, 8'd0, 1'b0);
    run_plan();

    // Random phases over a spread of register settings
    for (p = 0; p < 8; p++) begin
      add_cfg(REG_SEGMENT_SIZE, {16'($urandom_range(0, 65535)), segs[p][15:0]});
      add_cfg(REG_INITIAL_SEGMENTS, {27'($urandom_range(0, 32'h07ff_ffff)), inits[p][4:0]});
      fill_random(PhaseItems, segs[p], p == 2);
      run_plan();
    end

    drain();
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/reno_pkg.sv
rtl/core/reno_div.sv
rtl/core/reno_congestion_window.sv
tb/sv/testbench.sv
